FILE: design/eac3s_pkg.sv
package eac3s_pkg;

  // width of the stream position, frame start and frame counters
  localparam int unsigned COUNT_WIDTH = 32;

  localparam logic [7:0] SYNC_FIRST     = 8'h0B;
  localparam logic [7:0] SYNC_SECOND    = 8'h77;
  localparam logic [2:0] SIZE_HIGH_MASK = 3'h7;
  localparam int unsigned SIZE_SHIFT    = 8;

  // short frames (two or four bytes) end on the second size byte
  localparam logic [12:0] SHORT_FRAME_MAX = 13'd4;

  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_SYNC1   = 3'd1,
    PH_SIZE_HI = 3'd2,
    PH_SIZE_LO = 3'd3,
    PH_BODY    = 3'd4
  } phase_e;

  typedef struct packed {
    logic [12:0] frame_bytes;
    logic [31:0] frame_offset;
    logic [31:0] frame_number;
  } result_t;

  typedef struct packed {
    logic    emit;
    result_t res;
  } parse_out_t;

endpackage

FILE: design/eac3s_parser.sv
module eac3s_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic [7:0]          byte_i,
  input  logic [31:0]         base_offset_i,
  output eac3s_pkg::parse_out_t parse_o
);
  import eac3s_pkg::*;

  phase_e                 phase_q, phase_d;
  logic [2:0]             size_high_q, size_high_d;
  logic [11:0]            bytes_left_q, bytes_left_d;
  logic [12:0]            cur_len_q, cur_len_d;
  logic [COUNT_WIDTH-1:0] stream_pos_q;
  logic [COUNT_WIDTH-1:0] frame_start_q, frame_start_d;
  logic [COUNT_WIDTH-1:0] frames_found_q;

  logic [10:0] size_field;
  logic [11:0] size_plus1;
  logic [12:0] new_len;
  logic [11:0] left_dec;
  logic        emit;

  assign size_field = {size_high_q, byte_i};
  assign size_plus1 = {1'b0, size_field} + 12'd1;
  assign new_len    = {size_plus1, 1'b0};
  assign left_dec   = (bytes_left_q != 12'd0) ? bytes_left_q - 12'd1 : bytes_left_q;

  // next phase
  always_comb begin
    phase_d = phase_q;
    unique case (phase_q)
      PH_SYNC1: begin
        if (byte_i == SYNC_SECOND) begin
          phase_d = PH_SIZE_HI;
        end else if (byte_i != SYNC_FIRST) begin
          phase_d = PH_HUNT;
        end
      end
      PH_SIZE_HI: phase_d = PH_SIZE_LO;
      PH_SIZE_LO: phase_d = (new_len <= SHORT_FRAME_MAX) ? PH_HUNT : PH_BODY;
      PH_BODY:    phase_d = (left_dec == 12'd0) ? PH_HUNT : PH_BODY;
      default:    phase_d = (byte_i == SYNC_FIRST) ? PH_SYNC1 : PH_HUNT;
    endcase
  end

  // datapath and report
  always_comb begin
    size_high_d   = size_high_q;
    bytes_left_d  = bytes_left_q;
    cur_len_d     = cur_len_q;
    frame_start_d = frame_start_q;
    emit          = 1'b0;
    unique case (phase_q)
      PH_SYNC1: begin
        if (byte_i == SYNC_FIRST) begin
          frame_start_d = stream_pos_q;
        end
      end
      PH_SIZE_HI: size_high_d = byte_i[2:0] & SIZE_HIGH_MASK;
      PH_SIZE_LO: begin
        cur_len_d = new_len;
        if (new_len <= SHORT_FRAME_MAX) begin
          bytes_left_d = 12'd0;
          emit         = 1'b1;
        end else begin
          bytes_left_d = 12'(new_len - SHORT_FRAME_MAX);
        end
      end
      PH_BODY: begin
        bytes_left_d = left_dec;
        emit         = (left_dec == 12'd0);
      end
      default: begin
        if (byte_i == SYNC_FIRST) begin
          frame_start_d = stream_pos_q;
        end
      end
    endcase
  end

  assign parse_o.emit             = emit;
  assign parse_o.res.frame_number = 32'(frames_found_q);
  assign parse_o.res.frame_offset = base_offset_i + 32'(frame_start_q);
  assign parse_o.res.frame_bytes  = cur_len_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= PH_HUNT;
      size_high_q    <= '0;
      bytes_left_q   <= '0;
      cur_len_q      <= '0;
      stream_pos_q   <= '0;
      frame_start_q  <= '0;
      frames_found_q <= '0;
    end else if (step_i) begin
      phase_q       <= phase_d;
      size_high_q   <= size_high_d;
      bytes_left_q  <= bytes_left_d;
      cur_len_q     <= cur_len_d;
      stream_pos_q  <= stream_pos_q + COUNT_WIDTH'(1);
      frame_start_q <= frame_start_d;
      if (emit) begin
        frames_found_q <= frames_found_q + COUNT_WIDTH'(1);
      end
    end
  end

  a_body_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_BODY |-> bytes_left_q != 12'd0)
    else $error("frame body with no bytes left");

  a_count_on_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && emit |=> frames_found_q == $past(frames_found_q) + COUNT_WIDTH'(1))
    else $error("frame counter missed a report");

  a_hold_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_i |=> $stable(phase_q) && $stable(stream_pos_q) && $stable(frames_found_q))
    else $error("parser state moved without a byte");

  a_emit_ends_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && emit |=> phase_q == PH_HUNT)
    else $error("report without return to hunting");

endmodule

FILE: design/eac3s_out_reg.sv
module eac3s_out_reg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  eac3s_pkg::result_t res_i,
  input  logic               take_i,
  output logic               valid_o,
  output eac3s_pkg::result_t res_o
);
  import eac3s_pkg::*;

  logic    valid_q;
  result_t res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (take_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

FILE: design/eac3_sync_frame_scanner_core.sv
// channel   | direction | payload (lowest bit first)
// s_axis    | in        | data_byte[7:0]
// m_axis    | out       | frame_number[31:0], frame_offset[63:32], frame_bytes[76:64], zero pad
// cfg       | in        | base_offset[31:0]
//
// one word accepted per cycle, sustained, while the result side keeps up
// a frame's report is loaded into the result register when its last word leaves the input register
// the input register moves on whenever the result register is empty or being taken,
// so a stalled result holds the input register and s_axis_tready drops
// reset clears phase, counters, base_offset and both valid flags
// cfg is always ready; write it only while the scanner is idle
module eac3_sync_frame_scanner_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // slave side: data_byte[7:0]
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,
  // master side: frame_number[31:0], frame_offset[63:32], frame_bytes[76:64], pad
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata,
  // configuration: base_offset[31:0]
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_data_i
);
  import eac3s_pkg::*;

  logic        in_valid_q;
  logic [7:0]  in_byte_q;
  logic [31:0] base_offset_q;
  logic        advance;
  logic        out_valid;
  parse_out_t  parse;
  result_t     out_res;

  // the input word is consumed once the result register can take its report
  assign advance       = in_valid_q && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign cfg_ready_o   = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  // payload register, no reset needed
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_offset_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      base_offset_q <= cfg_data_i;
    end
  end

  // sync hunt, size decode and frame counting
  eac3s_parser u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (advance),
    .byte_i        (in_byte_q),
    .base_offset_i (base_offset_q),
    .parse_o       (parse)
  );

  // result register towards m_axis
  eac3s_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (advance && parse.emit),
    .res_i   (parse.res),
    .take_i  (m_axis_tready),
    .valid_o (out_valid),
    .res_o   (out_res)
  );

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {3'b000, out_res.frame_bytes, out_res.frame_offset,
                          out_res.frame_number};

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |-> !(out_valid && !m_axis_tready))
    else $error("report register overwritten while stalled");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_q |-> s_axis_tready)
    else $error("empty input register not ready");

  a_report_follows_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid) |-> $past(advance))
    else $error("report without a consumed word");

endmodule

FILE: dv/eac3s_tb_pkg.sv
`timescale 1ns / 1ps

package eac3s_tb_pkg;

  import eac3s_pkg::*;

  // frame delineation predictor plus the queue of frame reports still owed
  class frame_scoreboard;

    phase_e      phase;
    logic [2:0]  size_hi;
    logic [11:0] body_left;
    logic [12:0] frame_len;
    logic [31:0] position;
    logic [31:0] start_pos;
    logic [31:0] frame_count;
    logic [31:0] base;

    result_t     owed_frames[$];
    int unsigned frames_checked;
    int unsigned mismatches;

    function new();
      phase          = PH_HUNT;
      size_hi        = '0;
      body_left      = '0;
      frame_len      = '0;
      position       = '0;
      start_pos      = '0;
      frame_count    = '0;
      base           = '0;
      frames_checked = 0;
      mismatches     = 0;
    endfunction

    function void set_base(logic [31:0] value);
      base = value;
    endfunction

    function int pending();
      return owed_frames.size();
    endfunction

    function void close_frame();
      result_t r;
      r.frame_number = frame_count;
      r.frame_offset = base + start_pos;
      r.frame_bytes  = frame_len;
      owed_frames.push_back(r);
      frame_count = frame_count + 32'd1;
      phase       = PH_HUNT;
    endfunction

    // advance the scanner by one accepted word
    function void note_byte(logic [7:0] b);
      logic [31:0] here;
      logic [10:0] field;
      here     = position;
      position = position + 32'd1;
      case (phase)
        PH_SYNC1: begin
          if (b == SYNC_SECOND) begin
            phase = PH_SIZE_HI;
          end else if (b == SYNC_FIRST) begin
            start_pos = here;
          end else begin
            phase = PH_HUNT;
          end
        end
        PH_SIZE_HI: begin
          size_hi = b[2:0] & SIZE_HIGH_MASK;
          phase   = PH_SIZE_LO;
        end
        PH_SIZE_LO: begin
          field     = {size_hi, b};
          frame_len = (13'(field) + 13'd1) << 1;
          if (frame_len <= SHORT_FRAME_MAX) begin
            body_left = '0;
            close_frame();
          end else begin
            body_left = 12'(frame_len - 13'd4);
            phase     = PH_BODY;
          end
        end
        PH_BODY: begin
          if (body_left != 0) body_left = body_left - 12'd1;
          if (body_left == 0) close_frame();
        end
        default: begin
          if (b == SYNC_FIRST) begin
            start_pos = here;
            phase     = PH_SYNC1;
          end else begin
            phase = PH_HUNT;
          end
        end
      endcase
    endfunction

    function void check_frame(logic [79:0] word);
      result_t got;
      result_t want;
      got = result_t'(word[76:0]);
      if (owed_frames.size() == 0) begin
        $error("frame report with none owed: frame_number %0d", got.frame_number);
        mismatches++;
        return;
      end
      want = owed_frames.pop_front();
      frames_checked++;
      if (got.frame_number !== want.frame_number) begin
        $error("frame_number: expected %0d, got %0d", want.frame_number, got.frame_number);
        mismatches++;
      end
      if (got.frame_offset !== want.frame_offset) begin
        $error("frame_offset: expected 0x%08h, got 0x%08h", want.frame_offset,
               got.frame_offset);
        mismatches++;
      end
      if (got.frame_bytes !== want.frame_bytes) begin
        $error("frame_bytes: expected %0d, got %0d", want.frame_bytes, got.frame_bytes);
        mismatches++;
      end
    endfunction

  endclass

endpackage

FILE: dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  import eac3s_pkg::*;
  import eac3s_tb_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 600000;
  // word in input register, then result register; the settle margin covers both
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned PHASE_BYTES   = 620;

  typedef enum int {TX_NONE, TX_LONG_BURSTS, TX_SHORT_BURSTS} tx_style_e;
  typedef enum int {RX_ALWAYS, RX_COIN, RX_LONG_STALL, RX_ALTERNATE} rx_style_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [79:0] m_axis_tdata;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [31:0] cfg_data_i = '0;

  frame_scoreboard sb;

  tx_style_e   tx_style = TX_NONE;
  rx_style_e   rx_style = RX_ALWAYS;
  int unsigned burst_left = 0;
  int unsigned bytes_sent = 0;
  int unsigned base_writes = 0;
  int unsigned cycle_count = 0;
  logic [7:0]  rx_tick = '0;

  eac3_sync_frame_scanner_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // watchdog: a hung handshake or a lost report ends here
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // result side back-pressure, style chosen per phase
  always @(posedge clk_i) begin
    rx_tick <= rx_tick + 8'd1;
    case (rx_style)
      RX_ALWAYS:     m_axis_tready <= 1'b1;
      RX_COIN:       m_axis_tready <= 1'($urandom_range(0, 1));
      RX_LONG_STALL: m_axis_tready <= (rx_tick[4:3] == 2'b11);
      default:       m_axis_tready <= rx_tick[0];
    endcase
  end

  // every report taken from the master side is checked against the oldest owed frame
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_frame(m_axis_tdata);
  end

  // offer one word, respecting the burst and gap pattern; valid stays high across a burst
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    if (burst_left == 0) begin
      case (tx_style)
        TX_LONG_BURSTS: begin
          gap        = $urandom_range(1, 6);
          burst_left = $urandom_range(1, 40);
        end
        TX_SHORT_BURSTS: begin
          gap        = $urandom_range(1, 2);
          burst_left = $urandom_range(1, 3);
        end
        default: begin
          gap        = 0;
          burst_left = 1000;
        end
      endcase
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_byte(b);
    burst_left--;
    bytes_sent++;
  endtask

  // body bytes lean towards sync values, which must not be rescanned inside a frame
  function automatic logic [7:0] body_byte();
    int unsigned pick;
    pick = $urandom_range(0, 7);
    if (pick == 0) return SYNC_FIRST;
    if (pick == 1) return SYNC_SECOND;
    return 8'($urandom);
  endfunction

  // sync word, two size bytes and a body; cut >= 0 truncates the body
  task automatic send_frame(input logic [7:0] size2, input logic [7:0] size3, input int cut);
    logic [12:0] len;
    int          body;
    len  = (13'({size2[2:0], size3}) + 13'd1) << 1;
    body = (len > 13'd4) ? int'(len) - 4 : 0;
    if (cut >= 0 && cut < body) body = cut;
    send_byte(SYNC_FIRST);
    send_byte(SYNC_SECOND);
    send_byte(size2);
    send_byte(size3);
    repeat (body) send_byte(body_byte());
  endtask

  // stop offering, let every owed report arrive, then let the pipeline settle
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_base(input logic [31:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    sb.set_base(value);
    base_writes++;
  endtask

  // mostly well-formed frames with random content, the rest noise, broken syncs and cut-short frames
  task automatic random_stream(input int unsigned target);
    int unsigned first;
    int unsigned pick;
    int unsigned n;
    first = bytes_sent;
    while (bytes_sent - first < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 68) begin
        send_frame({5'($urandom), 3'b000}, 8'($urandom_range(0, 24)), -1);
      end else if (pick < 69) begin
        send_frame({5'($urandom), 3'b001}, 8'($urandom), -1);
      end else if (pick < 82) begin
        // loose noise between frames
        n = $urandom_range(1, 6);
        repeat (n) send_byte(($urandom_range(0, 3) == 0) ? SYNC_FIRST : 8'($urandom));
      end else if (pick < 92) begin
        // broken or repeated sync first byte
        n = $urandom_range(1, 3);
        repeat (n) send_byte(SYNC_FIRST);
        send_byte(($urandom_range(0, 1) == 0) ? 8'($urandom) : SYNC_FIRST);
      end else begin
        // frame cut short, the next frame is swallowed into its body
        send_frame({5'($urandom), 3'b000}, 8'($urandom_range(2, 24)),
                   $urandom_range(0, 3));
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part, offset wraps with an all-ones base
    write_base(32'hFFFF_FFFF);
    tx_style = TX_SHORT_BURSTS;
    rx_style = RX_ALTERNATE;
    send_byte(8'h00);
    send_byte(8'hFF);
    // repeated first sync byte, then a two-byte frame ending on its size byte
    send_byte(SYNC_FIRST);
    send_frame(8'h00, 8'h00, -1);
    // four-byte frame
    send_frame(8'h00, 8'h01, -1);
    // broken sync
    send_byte(SYNC_FIRST);
    send_byte(8'h12);
    // upper bits of the first size byte are ignored
    send_byte(SYNC_FIRST);
    send_byte(SYNC_SECOND);
    send_byte(8'hF8);
    send_byte(8'h02);
    send_byte(8'h5A);
    send_byte(8'hA5);
    // sync word inside a frame body is not a new frame
    send_byte(SYNC_FIRST);
    send_byte(SYNC_SECOND);
    send_byte(8'h00);
    send_byte(8'h03);
    send_byte(SYNC_FIRST);
    send_byte(SYNC_SECOND);
    send_byte(8'h00);
    send_byte(8'h00);
    drain();

    write_base(32'h0000_0000);
    tx_style = TX_LONG_BURSTS;
    rx_style = RX_COIN;
    random_stream(PHASE_BYTES);
    drain();

    write_base($urandom);
    tx_style = TX_SHORT_BURSTS;
    rx_style = RX_LONG_STALL;
    random_stream(PHASE_BYTES);
    drain();

    // flat out on both sides
    write_base(32'h8000_0000 | $urandom);
    tx_style = TX_NONE;
    rx_style = RX_ALWAYS;
    random_stream(PHASE_BYTES);
    // trailing partial frame, never reported
    send_frame(8'h07, 8'hFF, 20);
    drain();

    $display("stream of %0d bytes scanned under %0d base offset settings", bytes_sent,
             base_writes);
    $display("%0d frame reports compared, %0d field mismatches", sb.frames_checked,
             sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
